### rtl/lbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_pkg: shared definitions for the LED bar meter
// Register indexes, field widths, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package lbm_pkg;

  // Field widths fixed by the register map and the item formats
  localparam int VALUE_W   = 16;
  localparam int COLOR_W   = 24;
  localparam int IDX_W     = 6;
  localparam int RANGE_W   = 12;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Span of a range is 1..64 LEDs, product and quotient width
  localparam int LEN_W  = IDX_W + 1;
  localparam int QUO_W  = VALUE_W + LEN_W;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = VALUE_W'(100);

  // Parameter defaults
  localparam int DEF_MAX_RANGES = 4;
  localparam int DEF_LED_COUNT  = 64;
  localparam int DEF_RANGE_LEDS = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_ZERO  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_EMIT,
    ST_NEXT
  } lbm_state_t;

endpackage

### rtl/led_bar_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bar_meter: LED bar-graph meter
// Turns each meter value into one color write per LED over the configured
// ranges, up to RANGE_LEDS each, with a shared restoring divider and sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  meter    | in        | meter_valid/meter_stall | meter_value[15:0]
//  led      | out       | led_valid/led_stall     | led_index, led_color, last_write
//  cfg      | in        | cfg_we                  | cfg_index[2:0], cfg_data[23:0]
//
//  Each range takes a setup step, the divider steps (one quotient bit per
//  cycle), up to RANGE_LEDS writes and an advance step. meter_stall is high
//  from the cycle after a value is taken, when any range is set, until the
//  sequencer is back in idle, reached through ST_NEXT after its last write
//  enters the output register. led_stall holds the sequencer in the write
//  phase. Reset loads the register defaults; there is no clearing pass.
//
module led_bar_meter
  import lbm_pkg::*;
#(
  parameter int MAX_RANGES = DEF_MAX_RANGES,
  parameter int LED_COUNT  = DEF_LED_COUNT,
  parameter int RANGE_LEDS = DEF_RANGE_LEDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  meter_valid,
  output logic                  meter_stall,
  input  logic [VALUE_W-1:0]    meter_value,
  output logic                  led_valid,
  input  logic                  led_stall,
  output logic [IDX_W-1:0]      led_index,
  output logic [COLOR_W-1:0]    led_color,
  output logic                  last_write,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration
  logic [VALUE_W-1:0] max_value;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [COUNT_W-1:0] range_count;
  logic [RANGE_W-1:0] range_reg [MAX_RANGES];

  // Sequencer and datapath
  lbm_state_t         state, state_next;
  logic [VALUE_W-1:0] value;
  logic [VALUE_W-1:0] divisor;
  logic [COUNT_W-1:0] range_sel;
  logic [IDX_W-1:0]   start;
  logic               rising;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   hi_eff;
  logic [QUO_W-1:0]   quo;
  logic [VALUE_W-1:0] rem;
  logic [STEP_W-1:0]  step;

  // Strobes from the sequencer
  logic take_item, setup, div_step, emit_fire, adv_range;

  logic [COUNT_W-1:0] cnt_eff;
  logic [RANGE_W-1:0] cur_range;
  logic [IDX_W-1:0]   cur_s, cur_e, cur_lo, cur_hi;
  logic               cur_rising;
  logic [LEN_W-1:0]   cur_len;
  logic [LEN_W-1:0]   lo_plus;
  logic [IDX_W-1:0]   hi_lim;
  logic [VALUE_W:0]   rem_sh;
  logic               div_ge;
  logic               in_strip;
  logic               out_free;
  logic               range_end;
  logic               later_emit;
  logic               last_range;
  logic [IDX_W-1:0]   led_offset;
  logic               lit;

  assign cnt_eff = (range_count > COUNT_W'(MAX_RANGES)) ? COUNT_W'(MAX_RANGES) : range_count;
  assign last_range = (range_sel == cnt_eff - COUNT_W'(1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_value   <= MAX_VALUE_RESET;
      fg_color    <= '0;
      bg_color    <= '0;
      range_count <= '0;
      for (int j = 0; j < MAX_RANGES; j++) begin
        range_reg[j] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_VALUE)   max_value   <= cfg_data[VALUE_W-1:0];
      if (cfg_index == REG_FG_COLOR)    fg_color    <= cfg_data[COLOR_W-1:0];
      if (cfg_index == REG_BG_COLOR)    bg_color    <= cfg_data[COLOR_W-1:0];
      if (cfg_index == REG_RANGE_COUNT) range_count <= cfg_data[COUNT_W-1:0];
      for (int j = 0; j < MAX_RANGES; j++) begin
        if (cfg_index == REG_RANGE_ZERO + CFG_IDX_W'(j)) begin
          range_reg[j] <= cfg_data[RANGE_W-1:0];
        end
      end
    end
  end

  // Current range decode
  always_comb begin
    cur_range = '0;
    for (int j = 0; j < MAX_RANGES; j++) begin
      if (range_sel == COUNT_W'(j)) cur_range = range_reg[j];
    end
  end

  assign cur_s      = cur_range[IDX_W-1:0];
  assign cur_e      = cur_range[2*IDX_W-1:IDX_W];
  assign cur_rising = cur_e > cur_s;
  assign cur_lo     = cur_rising ? cur_s : cur_e;
  assign cur_hi     = cur_rising ? cur_e : cur_s;
  assign cur_len    = {1'b0, cur_hi} - {1'b0, cur_lo} + LEN_W'(1);
  // Truncate long ranges to their first RANGE_LEDS LEDs
  assign lo_plus    = {1'b0, cur_lo} + LEN_W'(RANGE_LEDS - 1);
  assign hi_lim     = (lo_plus < {1'b0, cur_hi}) ? lo_plus[IDX_W-1:0] : cur_hi;

  // Does any later range have an LED on the strip
  always_comb begin
    logic [IDX_W-1:0] s_j, e_j, lo_j;
    later_emit = 1'b0;
    for (int j = 0; j < MAX_RANGES; j++) begin
      s_j  = range_reg[j][IDX_W-1:0];
      e_j  = range_reg[j][2*IDX_W-1:IDX_W];
      lo_j = (e_j > s_j) ? s_j : e_j;
      if (COUNT_W'(j) > range_sel && COUNT_W'(j) < cnt_eff &&
          {1'b0, lo_j} < LEN_W'(LED_COUNT)) begin
        later_emit = 1'b1;
      end
    end
  end

  // Shared divider step
  assign rem_sh = {rem, quo[QUO_W-1]};
  assign div_ge = rem_sh >= {1'b0, divisor};

  // LED walk: lit while the distance from start is below the quotient
  assign in_strip   = {1'b0, idx} < LEN_W'(LED_COUNT);
  assign out_free   = !led_valid || !led_stall;
  assign range_end  = (idx == hi_eff) || ({1'b0, idx} == LEN_W'(LED_COUNT - 1));
  assign led_offset = rising ? (idx - start) : (start - idx);
  assign lit        = {{(QUO_W-IDX_W){1'b0}}, led_offset} < quo;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (meter_valid && cnt_eff != '0) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_DIV;
      ST_DIV:   if (step == STEP_W'(QUO_W - 1)) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!in_strip) state_next = ST_NEXT;
        else if (out_free && range_end) state_next = ST_NEXT;
      end
      ST_NEXT:  state_next = last_range ? ST_IDLE : ST_SETUP;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    take_item = 1'b0;
    setup     = 1'b0;
    div_step  = 1'b0;
    emit_fire = 1'b0;
    adv_range = 1'b0;
    case (state)
      ST_IDLE:  take_item = meter_valid;
      ST_SETUP: setup = 1'b1;
      ST_DIV:   div_step = 1'b1;
      ST_EMIT:  emit_fire = in_strip && out_free;
      ST_NEXT:  adv_range = !last_range;
      default:  ;
    endcase
  end

  assign meter_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      range_sel <= '0;
      led_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take_item) range_sel <= '0;
      else if (adv_range) range_sel <= range_sel + COUNT_W'(1);
      if (emit_fire) led_valid <= 1'b1;
      else if (!led_stall) led_valid <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (take_item) begin
      value   <= meter_value;
      divisor <= (max_value == '0) ? VALUE_W'(1) : max_value;
    end
    if (setup) begin
      start  <= cur_s;
      rising <= cur_rising;
      idx    <= cur_lo;
      hi_eff <= hi_lim;
      quo    <= QUO_W'(value) * QUO_W'(cur_len);
      rem    <= '0;
      step   <= '0;
    end
    if (div_step) begin
      rem  <= div_ge ? VALUE_W'(rem_sh - {1'b0, divisor}) : rem_sh[VALUE_W-1:0];
      quo  <= {quo[QUO_W-2:0], div_ge};
      step <= step + STEP_W'(1);
    end
    if (emit_fire) begin
      led_index  <= idx;
      led_color  <= lit ? fg_color : bg_color;
      last_write <= range_end && !later_emit;
      idx        <= idx + IDX_W'(1);
    end
  end

  // Assertions
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step < STEP_W'(QUO_W)))
    else $error("divider step count overran");

  a_emit_on_strip: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> ({1'b0, idx} < LEN_W'(LED_COUNT)))
    else $error("write issued for an LED past the strip");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && range_end && !later_emit) |=> (state == ST_NEXT && last_write))
    else $error("final write did not end the item");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (take_item && cnt_eff != '0) |=> meter_stall)
    else $error("sequencer not busy after taking an item");

endmodule

### tb/led_bar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bar_checker: scoreboard for the LED bar meter
// Follows the register writes, works out the LED writes that each accepted
// meter value must produce and compares them, in order, with the LED writes
// that leave the block.
// ----------------------------------------------------------------------------
module led_bar_checker
  import lbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  meter_valid,
  input  logic                  meter_stall,
  input  logic [VALUE_W-1:0]    meter_value,
  input  logic                  led_valid,
  input  logic                  led_stall,
  input  logic [IDX_W-1:0]      led_index,
  input  logic [COLOR_W-1:0]    led_color,
  input  logic                  last_write,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    writes_due
);

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } led_write_t;

  logic [VALUE_W-1:0] full_scale = MAX_VALUE_RESET;
  logic [COLOR_W-1:0] lit_color = '0;
  logic [COLOR_W-1:0] unlit_color = '0;
  logic [COUNT_W-1:0] ranges_used = '0;
  logic [RANGE_W-1:0] span_reg [DEF_MAX_RANGES];
  led_write_t         led_writes_q[$];
  int                 errors = 0;
  int                 due_count = 0;

  assign fail_count = errors;
  assign writes_due = due_count;

  task automatic report(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  // Queue the LED writes for one meter value; the last one carries last.
  function automatic void predict_writes(input logic [VALUE_W-1:0] value);
    longint     v, m, s, e, b, lo, hi;
    int         n_ranges;
    bit         rising, have;
    led_write_t pend;
    v = longint'(value);
    m = (full_scale == '0) ? 1 : longint'(full_scale);
    n_ranges = (ranges_used > DEF_MAX_RANGES) ? DEF_MAX_RANGES : int'(ranges_used);
    have = 1'b0;
    pend = '0;
    for (int r = 0; r < n_ranges; r++) begin
      s = longint'(span_reg[r][IDX_W-1:0]);
      e = longint'(span_reg[r][RANGE_W-1:IDX_W]);
      rising = e > s;
      if (rising) begin
        b = s - 1 + (v * (e - s + 1)) / m;
        lo = s;
        hi = e;
      end else begin
        b = s + 1 + (v * (e - s - 1)) / m;
        lo = e;
        hi = s;
      end
      // long range: boundary from the full span, writes from the first LEDs only
      if (hi - lo + 1 > DEF_RANGE_LEDS) hi = lo + DEF_RANGE_LEDS - 1;
      for (longint i = lo; i <= hi; i++) begin
        if (i >= DEF_LED_COUNT) continue;
        if (have) led_writes_q.push_back(pend);
        pend.index = IDX_W'(i);
        pend.color = (rising ? (i <= b) : (i >= b)) ? lit_color : unlit_color;
        pend.last = 1'b0;
        have = 1'b1;
      end
    end
    if (have) begin
      pend.last = 1'b1;
      led_writes_q.push_back(pend);
    end
  endfunction

  always @(posedge clk) begin : track
    led_write_t want;
    if (rst) begin
      full_scale = MAX_VALUE_RESET;
      lit_color = '0;
      unlit_color = '0;
      ranges_used = '0;
      for (int r = 0; r < DEF_MAX_RANGES; r++) span_reg[r] = '0;
      led_writes_q.delete();
    end else begin
      if (led_valid && !led_stall) begin
        if (led_writes_q.size() == 0) begin
          report($sformatf("unexpected LED write: index %0d color %06h last %0b",
                           led_index, led_color, last_write));
        end else begin
          want = led_writes_q.pop_front();
          if (led_index !== want.index)
            report($sformatf("led_index %0d, want %0d", led_index, want.index));
          if (led_color !== want.color)
            report($sformatf("led_color %06h at LED %0d, want %06h",
                             led_color, want.index, want.color));
          if (last_write !== want.last)
            report($sformatf("last_write %0b at LED %0d, want %0b",
                             last_write, want.index, want.last));
        end
      end
      if (meter_valid && !meter_stall) predict_writes(meter_value);
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_VALUE:   full_scale = cfg_data[VALUE_W-1:0];
          REG_FG_COLOR:    lit_color = cfg_data[COLOR_W-1:0];
          REG_BG_COLOR:    unlit_color = cfg_data[COLOR_W-1:0];
          REG_RANGE_COUNT: ranges_used = cfg_data[COUNT_W-1:0];
          default:         span_reg[2'(cfg_index - REG_RANGE_ZERO)] = cfg_data[RANGE_W-1:0];
        endcase
      end
    end
    due_count = led_writes_q.size();
  end

endmodule

### tb/tb_led_bar_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_bar_meter: testbench for the LED bar meter
// Walks the block through directed and random register settings, sends
// meter values with random gaps against a randomly stalling LED sink, and
// lets the checker compare every LED write.
// ----------------------------------------------------------------------------
module tb_led_bar_meter;
  import lbm_pkg::*;

  localparam int DRAIN_CYCLES    = 250;
  localparam int PRESSURE_CYCLES = 600;
  localparam int PHASE_ITEMS     = 50;
  localparam int RANDOM_PHASES   = 9;

  typedef struct packed {
    logic [VALUE_W-1:0]             max_value;
    logic [COLOR_W-1:0]             fg_color;
    logic [COLOR_W-1:0]             bg_color;
    logic [COUNT_W-1:0]             range_count;
    logic [3:0][RANGE_W-1:0]        spans;
  } meter_setting_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  meter_valid = 1'b0;
  logic                  meter_stall;
  logic [VALUE_W-1:0]    meter_value = '0;
  logic                  led_valid;
  logic                  led_stall = 1'b0;
  logic [IDX_W-1:0]      led_index;
  logic [COLOR_W-1:0]    led_color;
  logic                  last_write;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    writes_due;

  bit                    no_idle = 1'b0;
  bit                    pressure_req = 1'b0;
  logic [VALUE_W-1:0]    dir_vals[$];

  always #5 clk = ~clk;

  led_bar_meter u_top (
    .clk         (clk),
    .rst         (rst),
    .meter_valid (meter_valid),
    .meter_stall (meter_stall),
    .meter_value (meter_value),
    .led_valid   (led_valid),
    .led_stall   (led_stall),
    .led_index   (led_index),
    .led_color   (led_color),
    .last_write  (last_write),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  led_bar_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .meter_valid (meter_valid),
    .meter_stall (meter_stall),
    .meter_value (meter_value),
    .led_valid   (led_valid),
    .led_stall   (led_stall),
    .led_index   (led_index),
    .led_color   (led_color),
    .last_write  (last_write),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .writes_due  (writes_due)
  );

  function automatic logic [RANGE_W-1:0] make_span(input int first_led, input int last_led);
    return {6'(last_led), 6'(first_led)};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value(input logic [VALUE_W-1:0] full);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return full;
      2:       return full + 16'd1;
      3:       return full - 16'd1;
      4, 5:    return 16'($urandom_range(0, int'(full)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic meter_setting_t random_setting();
    meter_setting_t st;
    int             first_led, last_led;
    case ($urandom_range(0, 9))
      0:       st.max_value = '0;
      1:       st.max_value = 16'd1;
      2:       st.max_value = 16'hFFFF;
      3, 4:    st.max_value = 16'($urandom_range(2, 20));
      default: st.max_value = 16'($urandom);
    endcase
    st.fg_color = 24'($urandom);
    st.bg_color = 24'($urandom);
    case ($urandom_range(0, 9))
      0:       st.range_count = '0;
      1:       st.range_count = 3'($urandom_range(5, 7));
      default: st.range_count = 3'($urandom_range(1, 4));
    endcase
    for (int r = 0; r < 4; r++) begin
      if ($urandom_range(0, 1)) begin
        // short span around a random LED, either direction
        first_led = $urandom_range(0, 63);
        last_led = first_led + $urandom_range(0, 14) - 7;
        if (last_led < 0) last_led = 0;
        if (last_led > 63) last_led = 63;
        st.spans[r] = make_span(first_led, last_led);
      end else begin
        st.spans[r] = 12'($urandom);
      end
    end
    return st;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Junk in the unused high bits must be dropped by the block.
  task automatic program_regs(input meter_setting_t st, input logic [7:0] which);
    if (which[REG_MAX_VALUE]) write_reg(REG_MAX_VALUE, {8'($urandom), st.max_value});
    if (which[REG_FG_COLOR]) write_reg(REG_FG_COLOR, st.fg_color);
    if (which[REG_BG_COLOR]) write_reg(REG_BG_COLOR, st.bg_color);
    if (which[REG_RANGE_COUNT])
      write_reg(REG_RANGE_COUNT, {21'($urandom), st.range_count});
    for (int r = 0; r < 4; r++) begin
      if (which[REG_RANGE_ZERO + r])
        write_reg(CFG_IDX_W'(REG_RANGE_ZERO + r), {12'($urandom), st.spans[r]});
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      meter_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meter_valid <= 1'b1;
    meter_value <= v;
    do @(posedge clk); while (meter_stall);
  endtask

  task automatic wait_idle();
    meter_valid <= 1'b0;
    @(posedge clk);
    while (writes_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed(input meter_setting_t st, input logic [7:0] which);
    program_regs(st, which);
    foreach (dir_vals[k]) send_value(dir_vals[k]);
    wait_idle();
  endtask

  // LED sink: random stalls, a quiet mode, and one long hold on request
  initial begin : led_sink
    int r;
    forever begin
      if (pressure_req) begin
        pressure_req = 1'b0;
        led_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else if (no_idle) begin
        led_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          led_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 90) begin
          led_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          led_stall <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    meter_setting_t st;
    logic [7:0]     which;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: no ranges, nothing comes out
    st = '0;
    dir_vals = '{16'd0, 16'hFFFF};
    run_directed(st, 8'h00);

    // one rising range on the reset full scale and colors
    st.range_count = 3'd1;
    st.spans[0] = make_span(0, 9);
    which = '0;
    which[REG_RANGE_COUNT] = 1'b1;
    which[REG_RANGE_ZERO] = 1'b1;
    dir_vals = '{16'd0, 16'd50, 16'd99, 16'd100, 16'hFFFF};
    run_directed(st, which);

    // zero full scale, long rising and falling ranges, single LED
    st.max_value = '0;
    st.fg_color = 24'hFFFFFF;
    st.bg_color = 24'h000000;
    st.range_count = 3'd4;
    st.spans = {make_span(10, 12), make_span(5, 5), make_span(63, 0), make_span(0, 63)};
    dir_vals = '{16'd0, 16'd1, 16'hFFFF};
    run_directed(st, 8'hFF);

    // widest full scale, too many ranges, top of the strip
    st.max_value = 16'hFFFF;
    st.fg_color = 24'h000000;
    st.bg_color = 24'hFFFFFF;
    st.range_count = 3'd7;
    st.spans = {make_span(0, 1), make_span(63, 63), make_span(48, 63), make_span(20, 5)};
    dir_vals = '{16'd0, 16'd32767, 16'hFFFE, 16'hFFFF};
    run_directed(st, 8'hFF);

    // unit full scale, values above it
    st.max_value = 16'd1;
    st.fg_color = 24'h123456;
    st.bg_color = 24'hABCDEF;
    st.range_count = 3'd3;
    st.spans = {make_span(9, 9), make_span(0, 0), make_span(40, 20), make_span(31, 32)};
    dir_vals = '{16'd0, 16'd1, 16'd2, 16'hFFFF};
    run_directed(st, 8'hFF);

    st.max_value = 16'd1000;
    st.fg_color = 24'hA5A5A5;
    st.bg_color = 24'h5A5A5A;
    st.range_count = 3'd2;
    st.spans = {make_span(0, 0), make_span(0, 0), make_span(62, 47), make_span(8, 30)};
    dir_vals = '{16'd0, 16'd1, 16'd500, 16'd999, 16'd1000, 16'd1001};
    run_directed(st, 8'hFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      st = random_setting();
      if (p == 3) st.range_count = 3'd4;
      no_idle = (p == 5);
      program_regs(st, 8'hFF);
      // hold the sink off while values keep coming
      if (p == 3) pressure_req = 1'b1;
      repeat (PHASE_ITEMS) send_value(random_value(st.max_value));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // generous bound on the slowest legal run
  initial begin : watchdog
    #80_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/lbm_pkg.sv
rtl/led_bar_meter.sv
tb/led_bar_checker.sv
tb/tb_led_bar_meter.sv
